// ----- rtl/dlrs_pkg.sv -----
package dlrs_pkg;

   localparam int ValueWidth  = 31;
   localparam int DigitWidth  = 4;
   localparam int PassWidth   = 4;
   localparam int Radix       = 10;
   localparam int MaxPasses   = 10;

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_CLEAR,
      ST_COUNT,
      ST_PREFIX,
      ST_SCATTER,
      ST_NEXT,
      ST_EMIT
   } state_type;

   // digit and quotient from one divide-by-ten step
   typedef struct packed {
      logic [ValueWidth-1:0] quot;
      logic [DigitWidth-1:0] digit;
   } div10_type;

endpackage

// ----- rtl/dlrs_digit_unit.sv -----
// shared digit extractor: digit of a value at a given pass, one divide by ten per cycle
module dlrs_digit_unit (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [dlrs_pkg::ValueWidth-1:0]  value,
   input  logic [dlrs_pkg::PassWidth-1:0]   pass,
   output logic                             done,
   output logic [dlrs_pkg::DigitWidth-1:0]  digit
);
   import dlrs_pkg::*;

   logic [ValueWidth-1:0] work_ff, work_in;
   logic [PassWidth-1:0]  left_ff, left_in;
   logic                  busy_ff, busy_in;
   logic [DigitWidth-1:0] digit_ff, digit_in;
   logic                  done_ff, done_in;
   logic [ValueWidth+3:0] prod;
   div10_type             dv;

   // quotient by reciprocal multiply with one correction
   always_comb begin
      prod = 35'((64'(work_ff) * 64'd3435973837) >> 35);
      dv.quot = prod[ValueWidth-1:0];
      if (work_ff - dv.quot * 31'd10 >= 31'd10) dv.quot = dv.quot + 31'd1;
      dv.digit = DigitWidth'(work_ff - dv.quot * 31'd10);
   end

   always_comb begin
      work_in  = work_ff;
      left_in  = left_ff;
      busy_in  = busy_ff;
      digit_in = digit_ff;
      done_in  = 1'b0;
      if (start) begin
         work_in = value;
         left_in = pass;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (left_ff == '0) begin
            digit_in = dv.digit;
            busy_in  = 1'b0;
            done_in  = 1'b1;
         end else begin
            work_in = dv.quot;
            left_in = left_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      work_ff  <= work_in;
      left_ff  <= left_in;
      digit_ff <= digit_in;
   end

   assign done  = done_ff;
   assign digit = digit_ff;

   a_done_digit: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> digit_ff < 4'(Radix)) else $error("digit out of range");
   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff)) else $error("done without busy");
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff) else $error("start while busy");
endmodule

// ----- rtl/decimal_lsd_radix_sort_unit.sv -----
// loading: one item per cycle; after the last item each pass clears the histogram,
// counts the digit of every item and then scatters the items by that digit
// (one divide-by-ten step per digit position in the shared digit unit), with a prefix
// sum between counting and scattering and a buffer swap at the end, then results are emitted
// backpressure: input not ready from the last item until the last result is loaded
// reset: synchronous, clears control, counters and the pass register (10)
module decimal_lsd_radix_sort_unit #(
   parameter int MAX_VALUES = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // value[30:0], zero
   input  logic        req_tlast,   // last
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // sorted_value[30:0], zero
   output logic        rsp_tlast,   // last_res
   output logic        rsp_tuser,   // overflow
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [3:0]  csr_data     // digit_passes
);
   import dlrs_pkg::*;

   localparam int AW = $clog2(MAX_VALUES);
   localparam int CW = $clog2(MAX_VALUES + 1);

   // two buffers; side selects which is source
   logic [ValueWidth-1:0] buf_a [MAX_VALUES];
   logic [ValueWidth-1:0] buf_b [MAX_VALUES];
   logic [CW-1:0] counts_ff [Radix];

   state_type state_ff, state_in;
   logic [PassWidth-1:0] passes_ff;
   logic [PassWidth-1:0] pass_ff, pass_in;
   logic [CW-1:0] count_ff, count_in;  // loaded values
   logic [CW-1:0] idx_ff, idx_in;
   logic [CW-1:0] sum_ff, sum_in;
   logic          side_ff, side_in;    // 0: source is a
   logic          drop_ff, drop_in;
   logic          phase_ff, phase_in;  // 0: read/start, 1: wait digit
   logic [ValueWidth-1:0] rd_a_ff, rd_b_ff;
   logic          dg_start, dg_done;
   logic [DigitWidth-1:0] dg_digit;
   logic [PassWidth-1:0]  passes_eff;
   logic [ValueWidth-1:0] src_val;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [ValueWidth-1:0] rsp_val_ff;
   logic                  rsp_last_ff, rsp_over_ff;
   logic                  req_fire, load_wr, scat_wr, rsp_load;
   logic [AW-1:0]         rd_addr, wr_addr;
   logic [CW-1:0]         pos;

   assign passes_eff = (passes_ff == '0) ? 4'd1 :
                       (passes_ff > 4'(MaxPasses)) ? 4'(MaxPasses) : passes_ff;
   assign src_val   = side_ff ? rd_b_ff : rd_a_ff;
   assign req_fire  = req_tvalid && req_tready;
   assign csr_ready = 1'b1;
   assign pos       = counts_ff[dg_digit];

   dlrs_digit_unit u_digit (
      .clock(clock), .reset(reset), .start(dg_start), .value(src_val),
      .pass(pass_ff), .done(dg_done), .digit(dg_digit)
   );

   always_comb begin
      state_in     = state_ff;
      pass_in      = pass_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      sum_in       = sum_ff;
      side_in      = side_ff;
      drop_in      = drop_ff;
      phase_in     = phase_ff;
      rsp_valid_in = rsp_valid_ff;
      req_tready   = 1'b0;
      dg_start     = 1'b0;
      load_wr      = 1'b0;
      scat_wr      = 1'b0;
      rsp_load     = 1'b0;
      rd_addr      = idx_ff[AW-1:0];
      wr_addr      = count_ff[AW-1:0];
      if (rsp_valid_ff && rsp_tready) rsp_valid_in = 1'b0;
      unique case (state_ff)
         ST_LOAD: begin
            req_tready = 1'b1;
            if (req_fire) begin
               if (count_ff < CW'(MAX_VALUES)) begin
                  load_wr  = 1'b1;
                  count_in = count_ff + 1'b1;
               end else drop_in = 1'b1;
               if (req_tlast) begin
                  state_in = ST_CLEAR;
                  idx_in   = '0;
                  pass_in  = '0;
                  side_in  = 1'b0;
               end
            end
         end
         ST_CLEAR: begin
            idx_in = idx_ff + 1'b1;
            if (idx_ff == CW'(Radix - 1)) begin
               idx_in   = '0;
               rd_addr  = '0;
               phase_in = 1'b0;
               state_in = (count_ff == '0) ? ST_NEXT : ST_COUNT;
            end
         end
         ST_COUNT, ST_SCATTER: begin
            // phase 0: memory read issued last cycle lands; start digit unit
            if (!phase_ff) begin
               dg_start = 1'b1;
               phase_in = 1'b1;
            end else if (dg_done) begin
               phase_in = 1'b0;
               if (state_ff == ST_SCATTER) scat_wr = 1'b1;
               idx_in  = idx_ff + 1'b1;
               rd_addr = idx_in[AW-1:0];
               if (idx_in == count_ff) begin
                  idx_in = '0;
                  sum_in = '0;
                  state_in = (state_ff == ST_COUNT) ? ST_PREFIX : ST_NEXT;
               end
            end
            wr_addr = pos[AW-1:0];
         end
         ST_PREFIX: begin
            sum_in = sum_ff + counts_ff[idx_ff[DigitWidth-1:0]];
            idx_in = idx_ff + 1'b1;
            if (idx_ff == CW'(Radix - 1)) begin
               idx_in   = '0;
               rd_addr  = '0;
               phase_in = 1'b0;
               state_in = ST_SCATTER;
            end
         end
         ST_NEXT: begin
            side_in = ~side_ff;
            idx_in  = '0;
            rd_addr = '0;
            if (pass_ff + 1'b1 >= passes_eff) begin
               state_in = (count_ff == '0) ? ST_LOAD : ST_EMIT;
               phase_in = 1'b0;
               if (count_ff == '0) drop_in = 1'b0;
            end else begin
               pass_in  = pass_ff + 1'b1;
               state_in = ST_CLEAR;
            end
         end
         ST_EMIT: begin
            // phase 0 waits for the read register to hold entry idx
            if (!phase_ff) phase_in = 1'b1;
            else if (!rsp_valid_ff || rsp_tready) begin
               rsp_load     = 1'b1;
               rsp_valid_in = 1'b1;
               idx_in       = idx_ff + 1'b1;
               rd_addr      = idx_in[AW-1:0];
               phase_in     = 1'b0;
               if (idx_in == count_ff) begin
                  state_in = ST_LOAD;
                  count_in = '0;
                  drop_in  = 1'b0;
                  pass_in  = '0;
                  idx_in   = '0;
               end
            end
         end
         default: state_in = ST_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         passes_ff    <= 4'(MaxPasses);
         pass_ff      <= '0;
         count_ff     <= '0;
         idx_ff       <= '0;
         sum_ff       <= '0;
         side_ff      <= 1'b0;
         drop_ff      <= 1'b0;
         phase_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pass_ff      <= pass_in;
         count_ff     <= count_in;
         idx_ff       <= idx_in;
         sum_ff       <= sum_in;
         side_ff      <= side_in;
         drop_ff      <= drop_in;
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid) passes_ff <= csr_data;
      end
   end

   // histogram: cleared, counted, rewritten in place as running offsets, then incremented while scattering
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < Radix; i++) counts_ff[i] <= '0;
      end else if (state_ff == ST_CLEAR) begin
         counts_ff[idx_ff[DigitWidth-1:0]] <= '0;
      end else if (state_ff == ST_PREFIX) begin
         counts_ff[idx_ff[DigitWidth-1:0]] <= sum_ff;
      end else if ((state_ff == ST_COUNT || state_ff == ST_SCATTER) && phase_ff && dg_done) begin
         counts_ff[dg_digit] <= counts_ff[dg_digit] + 1'b1;
      end
   end

   // buffer memories, registered reads
   always_ff @(posedge clock) begin
      if ((load_wr) || (scat_wr && side_ff))
         buf_a[wr_addr] <= load_wr ? req_tdata[ValueWidth-1:0] : src_val;
      if (scat_wr && !side_ff) buf_b[wr_addr] <= src_val;
      rd_a_ff <= buf_a[rd_addr];
      rd_b_ff <= buf_b[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_val_ff  <= src_val;
         rsp_last_ff <= (idx_ff + 1'b1 == count_ff);
         rsp_over_ff <= drop_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_val_ff};
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_over_ff;

   a_count_cap: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_VALUES)) else $error("load count beyond capacity");
   a_ready_load: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> state_ff == ST_LOAD) else $error("ready outside load");
   a_pass_range: assert property (@(posedge clock) disable iff (reset)
      pass_ff < 4'(MaxPasses)) else $error("pass index out of range");
   a_scatter_pos: assert property (@(posedge clock) disable iff (reset)
      scat_wr |-> pos < count_ff) else $error("scatter beyond run");
endmodule
